/* rtl/core/ercs_pkg.sv */
package ercs_pkg;

	localparam int ADDR_W      = 19;
	localparam int LEN_W       = 9;
	localparam int WORD_W      = 16;
	localparam int DEV_W       = 7;
	localparam int PAGE_W      = 9;
	localparam int MAX_LENGTH  = 256;
	localparam int MAX_RESULTS = 33;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int DIV_CNT_W   = $clog2(ADDR_W);
	localparam int CFG_IDX_W   = 2;

	localparam logic [PAGE_W-1:0] PAGE_MIN = PAGE_W'(8);
	localparam logic [PAGE_W-1:0] PAGE_MAX = PAGE_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAGE_SIZE  = 2'd0,
		REG_WORD_BYTES = 2'd1,
		REG_BLOCK_BITS = 2'd2,
		REG_DEV_BASE   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] start_address;
		logic [LEN_W-1:0]  request_length;
	} req_t;

	typedef struct packed {
		logic [DEV_W-1:0]  bus_device_address;
		logic [WORD_W-1:0] word_offset;
		logic [ADDR_W-1:0] chunk_address;
		logic [LEN_W-1:0]  chunk_length;
		logic              last_chunk;
	} chunk_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_size;
		logic [1:0]        addr_bytes;
		logic [1:0]        blk_sel_bits;
		logic [DEV_W-1:0]  device_base_address;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic len_zero;
		logic out_free;
		logic emit_last;
		logic emit_wrap;
	} status_t;

endpackage

/* rtl/core/ercs_regs.sv */
module ercs_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ercs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ercs_pkg::PAGE_W-1:0]     cfg_data,
	output ercs_pkg::cfg_t                  cfg
);
	import ercs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.page_size           <= PAGE_W'(16);
			cfg_q.addr_bytes          <= 2'd1;
			cfg_q.blk_sel_bits        <= 2'd0;
			cfg_q.device_base_address <= DEV_W'(80);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_PAGE_SIZE:  cfg_q.page_size           <= cfg_data;
				REG_WORD_BYTES: cfg_q.addr_bytes          <= cfg_data[1:0];
				REG_BLOCK_BITS: cfg_q.blk_sel_bits        <= cfg_data[1:0];
				REG_DEV_BASE:   cfg_q.device_base_address <= cfg_data[DEV_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/ercs_ctrl.sv */
module ercs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ercs_pkg::status_t   status,
	output ercs_pkg::cmd_t      cmd
);
	import ercs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && req_valid;
		cmd.step = (state_q == ST_DIV);
		cmd.emit = (state_q == ST_EMIT) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_DIV;
				end
				ST_DIV: begin
					// drop zero-length requests once the divider is done
					if (status.div_last) state_q <= status.len_zero ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (status.out_free) begin
						if (status.emit_last)      state_q <= ST_IDLE;
						else if (status.emit_wrap) state_q <= ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/ercs_dp.sv */
module ercs_dp #(
	parameter int MAX_LENGTH = ercs_pkg::MAX_LENGTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ercs_pkg::req_t      req,
	input  ercs_pkg::cfg_t      cfg,
	input  ercs_pkg::cmd_t      cmd,
	output ercs_pkg::status_t   status,
	output logic                chunk_valid,
	input  logic                chunk_stall,
	output ercs_pkg::chunk_t    chunk
);
	import ercs_pkg::*;

	localparam int CLAMP = (MAX_LENGTH < (1 << LEN_W) - 1) ? MAX_LENGTH : (1 << LEN_W) - 1;
	localparam logic [LEN_W-1:0] LEN_CLAMP = LEN_W'(CLAMP);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ADDR_W - 1);

	logic [ADDR_W-1:0]    addr_q;
	logic [LEN_W-1:0]     len_q;
	logic                 prog_q;
	logic [CNT_W-1:0]     n_q;
	logic [PAGE_W-1:0]    off_q;
	logic [ADDR_W-1:0]    dsh_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	logic                 out_valid_q;
	chunk_t               out_q;

	logic [PAGE_W-1:0] page_eff;
	logic              wide;
	logic [PAGE_W:0]   trial;
	logic [PAGE_W:0]   trial_sub;
	logic [PAGE_W-1:0] rem_next;
	logic [WORD_W-1:0] low_blk;
	logic [WORD_W:0]   room_blk;
	logic [PAGE_W-1:0] room_page;
	logic [LEN_W-1:0]  len_page;
	logic [LEN_W-1:0]  chunk_len;
	logic [ADDR_W:0]   addr_sum;
	logic [PAGE_W:0]   off_sum;
	logic [LEN_W-1:0]  len_next;
	logic [CNT_W-1:0]  n_next;
	logic              last;
	logic [2:0]        blk_mask;
	logic [2:0]        blk_num;
	logic [DEV_W-1:0]  dev;
	logic [LEN_W-1:0]  req_len;

	always_comb begin
		if (cfg.page_size < PAGE_MIN)      page_eff = PAGE_MIN;
		else if (cfg.page_size > PAGE_MAX) page_eff = PAGE_MAX;
		else                               page_eff = cfg.page_size;
	end

	assign wide = cfg.addr_bytes[1];
	assign req_len = (req.request_length > LEN_CLAMP) ? LEN_CLAMP : req.request_length;

	// one restoring step of the page remainder
	assign trial     = {off_q, dsh_q[ADDR_W-1]};
	assign trial_sub = trial - {1'b0, page_eff};
	assign rem_next  = (trial >= {1'b0, page_eff}) ? trial_sub[PAGE_W-1:0] : trial[PAGE_W-1:0];

	always_comb begin
		low_blk  = wide ? addr_q[WORD_W-1:0] : {8'd0, addr_q[7:0]};
		room_blk = (wide ? (17'd1 << 16) : 17'd256) - {1'b0, low_blk};
		room_page = page_eff - off_q;
		len_page = (prog_q && (room_page < len_q)) ? room_page : len_q;
		chunk_len = ({8'd0, len_page} > room_blk) ? room_blk[LEN_W-1:0] : len_page;
		addr_sum = {1'b0, addr_q} + {11'd0, chunk_len};
		off_sum  = {1'b0, off_q} + {1'b0, chunk_len};
		len_next = len_q - chunk_len;
		n_next   = n_q + CNT_W'(1);
		last     = (len_next == '0) || (n_next == CNT_W'(MAX_RESULTS));
	end

	always_comb begin
		unique case (cfg.blk_sel_bits)
			2'd0:    blk_mask = 3'b000;
			2'd1:    blk_mask = 3'b001;
			2'd2:    blk_mask = 3'b011;
			default: blk_mask = 3'b111;
		endcase
		blk_num = wide ? addr_q[18:16] : addr_q[10:8];
		dev = (cfg.device_base_address & ~{4'd0, blk_mask}) | {4'd0, blk_num & blk_mask};
	end

	always_comb begin
		status           = '0;
		status.div_last  = (dcnt_q == DIV_LAST);
		status.len_zero  = (len_q == '0);
		status.out_free  = !out_valid_q || !chunk_stall;
		status.emit_last = last;
		status.emit_wrap = prog_q && addr_sum[ADDR_W];
	end

	assign chunk_valid = out_valid_q;
	assign chunk       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!chunk_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= req.start_address;
			len_q  <= req_len;
			prog_q <= req.func;
			n_q    <= '0;
			off_q  <= '0;
			dsh_q  <= req.start_address;
			dcnt_q <= '0;
		end else if (cmd.step) begin
			off_q  <= rem_next;
			dsh_q  <= {dsh_q[ADDR_W-2:0], 1'b0};
			dcnt_q <= dcnt_q + DIV_CNT_W'(1);
		end else if (cmd.emit) begin
			out_q.bus_device_address <= dev;
			out_q.word_offset        <= low_blk;
			out_q.chunk_address      <= addr_q;
			out_q.chunk_length       <= chunk_len;
			out_q.last_chunk         <= last;
			addr_q <= addr_sum[ADDR_W-1:0];
			len_q  <= len_next;
			n_q    <= n_next;
			if (prog_q) begin
				if (addr_sum[ADDR_W]) begin
					// address wrapped: redo the page remainder from the new address
					off_q  <= '0;
					dsh_q  <= addr_sum[ADDR_W-1:0];
					dcnt_q <= '0;
				end else begin
					off_q <= (off_sum == {1'b0, page_eff}) ? '0 : off_sum[PAGE_W-1:0];
				end
			end
		end
	end

endmodule

/* rtl/core/eeprom_request_chunk_splitter.sv */
// Splits one EEPROM request (read or program, 19-bit start address, byte length)
// into I2C chunk plans. Each plan gives the bus device address with the block
// number merged into its low block-select bits, the word offset within
// the block, the absolute chunk address, its length and a last-chunk flag.
// Reads break only at block boundaries (256 or 65536 bytes); programs also
// break at page boundaries. Zero-length requests produce nothing. A request
// takes a bit-serial page-remainder pass over the start address, then gives
// one chunk per cycle (up to 33 chunks) while the output is not stalled;
// a program request whose address wraps past the top reruns the pass.
// A request is taken only while the controller is idle; the last chunk may
// still sit in the output register when the next request is accepted.
// Configuration registers must be written through cfg_valid/cfg_ready while
// no request is in flight (not enforced by the block); cfg_ready is always high.
module eeprom_request_chunk_splitter #(
	parameter int MAX_LENGTH = ercs_pkg::MAX_LENGTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  ercs_pkg::req_t                  req,
	// chunk plan channel
	output logic                            chunk_valid,
	input  logic                            chunk_stall,
	output ercs_pkg::chunk_t                chunk,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ercs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ercs_pkg::PAGE_W-1:0]     cfg_data
);
	import ercs_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// configuration registers, read directly by the datapath
	ercs_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequence load, remainder steps and chunk emission
	ercs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// address/length bookkeeping, page remainder and output register
	ercs_dp #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cfg         (cfg),
		.cmd         (cmd),
		.status      (status),
		.chunk_valid (chunk_valid),
		.chunk_stall (chunk_stall),
		.chunk       (chunk)
	);

endmodule

/* rtl/core/ercs_checker.sv */
module ercs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  logic                            chunk_valid,
	input  logic                            chunk_stall,
	input  ercs_pkg::chunk_t                chunk
);
	import ercs_pkg::*;

	logic              pend_q;
	logic [ADDR_W-1:0] exp_addr_q;
	logic [ADDR_W:0]   nxt;

	assign nxt = {1'b0, chunk.chunk_address} + {11'd0, chunk.chunk_length};

	// track where the next chunk of the same request must start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (chunk_valid && !chunk_stall) begin
			pend_q <= !chunk.last_chunk;
		end
	end

	always_ff @(posedge clk) begin
		if (chunk_valid && !chunk_stall) exp_addr_q <= nxt[ADDR_W-1:0];
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid && chunk_stall |=> chunk_valid && $stable(chunk))
		else $error("stalled chunk item changed");

	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid && pend_q |-> chunk.chunk_address == exp_addr_q)
		else $error("chunk does not follow previous chunk");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous one in flight");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid |-> chunk.chunk_length != '0 && chunk.chunk_length <= LEN_W'(256))
		else $error("chunk length out of range");

endmodule

bind eeprom_request_chunk_splitter ercs_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.chunk_valid (chunk_valid),
	.chunk_stall (chunk_stall),
	.chunk       (chunk)
);

/* sim/eeprom_request_chunk_splitter_chk.sv */
// Watches the request, chunk plan and configuration channels, predicts the
// chunk plans of every accepted request and compares them as they come out.
module chunk_plan_checker
	import ercs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  req_t                 req,
	input  logic                 chunk_valid,
	input  logic                 chunk_stall,
	input  chunk_t               chunk,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAGE_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   pending
);

	logic [PAGE_W-1:0] page_reg;
	logic [1:0]        word_bytes_reg;
	logic [1:0]        block_bits_reg;
	logic [DEV_W-1:0]  dev_base_reg;

	chunk_t plans_due[$];
	int     reported;

	initial begin
		mismatches = 0;
		pending    = 0;
		reported   = 0;
	end

	function automatic void split_request(input req_t r);
		logic [31:0]      addr;
		logic [31:0]      remaining;
		logic [31:0]      page;
		logic [31:0]      blk_bytes;
		logic [31:0]      span;
		logic [31:0]      room;
		logic [31:0]      mask;
		logic [DEV_W-1:0] dev;
		chunk_t           c;
		int               n;

		page = 32'(page_reg);
		if (page < 32'(PAGE_MIN))
			page = 32'(PAGE_MIN);
		if (page > 32'(PAGE_MAX))
			page = 32'(PAGE_MAX);
		blk_bytes = word_bytes_reg[1] ? 32'd65536 : 32'd256;
		mask      = (32'd1 << block_bits_reg) - 32'd1;

		addr      = 32'(r.start_address);
		remaining = 32'(r.request_length);
		if (remaining > 32'(MAX_LENGTH))
			remaining = 32'(MAX_LENGTH);
		n = 0;

		while (remaining != 0 && n < MAX_RESULTS) begin
			span = remaining;
			// program chunks also stop at the page edge
			if (r.func) begin
				room = page - (addr % page);
				if (room < span)
					span = room;
			end
			room = blk_bytes - (addr % blk_bytes);
			if (room < span)
				span = room;

			dev = dev_base_reg;
			if (block_bits_reg != 2'd0)
				dev = (dev & ~DEV_W'(mask)) | DEV_W'((addr / blk_bytes) & mask);

			c.bus_device_address = dev;
			c.word_offset        = WORD_W'(addr % blk_bytes);
			c.chunk_address      = ADDR_W'(addr);
			c.chunk_length       = LEN_W'(span);
			remaining            = remaining - span;
			n++;
			c.last_chunk         = (remaining == 0 || n == MAX_RESULTS);
			plans_due.push_back(c);
			addr = 32'(ADDR_W'(addr + span));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chunk_t want;
		logic   bad;

		if (!arst_n) begin
			page_reg       <= PAGE_W'(16);
			word_bytes_reg <= 2'd1;
			block_bits_reg <= 2'd0;
			dev_base_reg   <= DEV_W'(80);
			plans_due.delete();
			pending = 0;
		end else begin
			if (chunk_valid && !chunk_stall) begin
				if (plans_due.size() == 0) begin
					mismatches++;
					if (reported < 10) begin
						reported++;
						$display("unexpected chunk plan: %p", chunk);
					end
				end else begin
					want = plans_due.pop_front();
					bad  = 1'b0;
					if (chunk.bus_device_address !== want.bus_device_address)
						bad = 1'b1;
					if (chunk.word_offset !== want.word_offset)
						bad = 1'b1;
					if (chunk.chunk_address !== want.chunk_address)
						bad = 1'b1;
					if (chunk.chunk_length !== want.chunk_length)
						bad = 1'b1;
					if (chunk.last_chunk !== want.last_chunk)
						bad = 1'b1;
					if (bad) begin
						mismatches++;
						if (reported < 10) begin
							reported++;
							$display("chunk plan mismatch: expected %p, got %p", want, chunk);
						end
					end
				end
			end

			// a request is split with the configuration in force at acceptance
			if (req_valid && !req_stall)
				split_request(req);

			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					REG_PAGE_SIZE:  page_reg       <= cfg_data;
					REG_WORD_BYTES: word_bytes_reg <= cfg_data[1:0];
					REG_BLOCK_BITS: block_bits_reg <= cfg_data[1:0];
					REG_DEV_BASE:   dev_base_reg   <= cfg_data[DEV_W-1:0];
					default: ;
				endcase
			end

			pending = plans_due.size();
		end
	end

endmodule

/* sim/eeprom_request_chunk_splitter_test.sv */
// Stimulus and verdict for the request chunk splitter. The checker beside the
// block does all prediction and comparison; this module only drives items,
// writes settings between phases and decides pass or fail.
module eeprom_request_chunk_splitter_test;
	import ercs_pkg::*;

	// request kinds as carried in the func field
	localparam logic FUNC_READ    = 1'b0;
	localparam logic FUNC_PROGRAM = 1'b1;

	// settle time after the last plan: two address passes plus margin
	localparam int DRAIN_CYCLES     = 64;
	// cycles without any accepted item before the run is declared hung
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int NUM_PHASES       = 9;
	localparam int RANDOM_PER_PHASE = 46;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 chunk_valid;
	logic                 chunk_stall;
	chunk_t               chunk;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAGE_W-1:0]    cfg_data;

	int mismatches;
	int pending;
	int burst_left;
	int idle_cycles;

	eeprom_request_chunk_splitter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.chunk_valid (chunk_valid),
		.chunk_stall (chunk_stall),
		.chunk       (chunk),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	chunk_plan_checker plan_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.chunk_valid (chunk_valid),
		.chunk_stall (chunk_stall),
		.chunk       (chunk),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver back-pressure: switch between a few stall styles every so often
	// so that stalls land on first, middle and last chunks alike, with quiet
	// stretches where the output drains at full rate.
	int stall_mode;
	int stall_timer;

	initial begin
		chunk_stall = 1'b0;
		stall_mode  = 0;
		stall_timer = 0;
	end

	always @(negedge clk) begin
		if (stall_timer == 0) begin
			stall_mode  = $urandom_range(0, 3);
			stall_timer = $urandom_range(20, 200);
		end else begin
			stall_timer--;
		end
		case (stall_mode)
			0: chunk_stall = 1'b0;
			1: chunk_stall = ($urandom_range(0, 3) == 0);
			2: chunk_stall = ($urandom_range(0, 3) != 0);
			default: chunk_stall = ~chunk_stall;
		endcase
	end

	// Watchdog: restart on any accepted item on any channel.
	initial idle_cycles = 0;

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (chunk_valid && !chunk_stall) ||
		    (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic req_t make_req(input logic f, input logic [ADDR_W-1:0] a,
	                                  input logic [LEN_W-1:0] l);
		req_t r;

		r.func           = f;
		r.start_address  = a;
		r.request_length = l;
		return r;
	endfunction

	// Random request: addresses cluster around page, block and top-of-space
	// edges where the split logic does its work; lengths favor the clipped,
	// full and tiny cases beside the plain random spread.
	function automatic req_t random_req();
		req_t             r;
		int               kind;
		int               len_kind;
		logic [ADDR_W-1:0] a;

		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: a = ADDR_W'($urandom);
			4:          a = (ADDR_W'($urandom) & ~ADDR_W'(255)) -
			                ADDR_W'($urandom_range(0, 40));
			5:          a = {3'($urandom), 16'h0} - ADDR_W'($urandom_range(0, 300));
			6:          a = ADDR_W'(19'h7FFFF) - ADDR_W'($urandom_range(0, 300));
			7:          a = ADDR_W'($urandom) & ~ADDR_W'(7);
			default:    a = ADDR_W'($urandom_range(0, 1023));
		endcase

		len_kind = $urandom_range(0, 19);
		case (len_kind)
			0:          r.request_length = '0;
			1, 2:       r.request_length = LEN_W'($urandom_range(257, 511));
			3, 4, 5:    r.request_length = LEN_W'(256);
			6, 7, 8, 9: r.request_length = LEN_W'($urandom_range(1, 8));
			default:    r.request_length = LEN_W'($urandom_range(0, 256));
		endcase

		r.func          = $urandom_range(0, 1) ? FUNC_PROGRAM : FUNC_READ;
		r.start_address = a;
		return r;
	endfunction

	// Present one item and hold it until the block takes it. Open a new burst
	// after a random gap whenever the current one runs out.
	task automatic push_request(input req_t r);
		int gap;

		if (burst_left == 0) begin
			req_valid = 1'b0;
			case ($urandom_range(0, 3))
				0:       gap = 0;
				1:       gap = $urandom_range(20, 40);
				default: gap = $urandom_range(1, 12);
			endcase
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		req       = r;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [PAGE_W-1:0] data);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Drop valid, wait for every expected plan, then let zero-length or
	// in-flight work settle before touching the settings.
	task automatic wait_drained();
		req_valid  = 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [PAGE_W-1:0] page;
		logic [1:0]        word_bytes;
		logic [1:0]        block_bits;
		logic [DEV_W-1:0]  dev_base;

		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_PAGE_SIZE;
		cfg_data   = '0;
		burst_left = 0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// phase 0 runs on the reset settings, every later one writes all four
			if (phase != 0) begin
				wait_drained();
				case (phase)
					1: begin page = 9'd8;   word_bytes = 2'd1; block_bits = 2'd3; dev_base = 7'd127; end
					2: begin page = 9'd256; word_bytes = 2'd2; block_bits = 2'd3; dev_base = 7'd0;   end
					3: begin page = 9'd0;   word_bytes = 2'd0; block_bits = 2'd1; dev_base = 7'd85;  end
					4: begin page = 9'd511; word_bytes = 2'd3; block_bits = 2'd2; dev_base = 7'd42;  end
					5: begin page = 9'd64;  word_bytes = 2'd1; block_bits = 2'd2;
					         dev_base = 7'($urandom); end
					6: begin page = 9'd7;   word_bytes = 2'd2; block_bits = 2'd0; dev_base = 7'd127; end
					7: begin page = 9'd257; word_bytes = 2'd1; block_bits = 2'd1; dev_base = 7'd0;   end
					default: begin
						page       = 9'($urandom);
						word_bytes = 2'($urandom);
						block_bits = 2'($urandom);
						dev_base   = 7'($urandom);
					end
				endcase
				// upper data bits of the narrow registers carry noise to be dropped
				write_register(REG_PAGE_SIZE, page);
				write_register(REG_WORD_BYTES, {7'($urandom), word_bytes});
				write_register(REG_BLOCK_BITS, {7'($urandom), block_bits});
				write_register(REG_DEV_BASE, {2'($urandom), dev_base});
			end

			case (phase)
				0: begin
					// reset settings: 16-byte pages, 256-byte blocks, device 0x50
					push_request(make_req(FUNC_READ,    19'h00000, 9'd256));
					push_request(make_req(FUNC_PROGRAM, 19'h00000, 9'd256));
					push_request(make_req(FUNC_READ,    19'h00123, 9'd0));
					push_request(make_req(FUNC_PROGRAM, 19'h00005, 9'd511));
					push_request(make_req(FUNC_PROGRAM, 19'h7FFF8, 9'd20));
					push_request(make_req(FUNC_READ,    19'h7FFFF, 9'd256));
					push_request(make_req(FUNC_READ,    19'h7FFFF, 9'd1));
					push_request(make_req(FUNC_PROGRAM, 19'h000FF, 9'd2));
				end
				1: begin
					// smallest pages: an unaligned full request gives the most chunks
					push_request(make_req(FUNC_PROGRAM, 19'h00003, 9'd256));
					push_request(make_req(FUNC_PROGRAM, 19'h00000, 9'd256));
					push_request(make_req(FUNC_READ,    19'h000FF, 9'd2));
					push_request(make_req(FUNC_READ,    19'h503F0, 9'd256));
					push_request(make_req(FUNC_PROGRAM, 19'h7FFFC, 9'd256));
					push_request(make_req(FUNC_PROGRAM, 19'h01234, 9'd0));
					push_request(make_req(FUNC_READ,    19'h12345, 9'd300));
				end
				2: begin
					// two word-address bytes: cross 64 KiB blocks and the top
					push_request(make_req(FUNC_READ,    19'h1FF80, 9'd256));
					push_request(make_req(FUNC_PROGRAM, 19'h7FF80, 9'd256));
					push_request(make_req(FUNC_READ,    19'h7FFFF, 9'd256));
					push_request(make_req(FUNC_PROGRAM, 19'h0FFFF, 9'd3));
				end
				default: ;
			endcase

			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				push_request(random_req());
		end

		wait_drained();

		if (mismatches == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
